FILE: src/hbt_pkg.sv
package hbt_pkg;

    localparam int DATA_W         = 16;
    localparam int BLOCK_SIZE_DEF = 8;

    // Sequencer states: load, the four steps of one butterfly, and the two
    // steps of one emitted coefficient.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RD_A,
        ST_RD_B,
        ST_WR_LO,
        ST_WR_HI,
        ST_EM_RD,
        ST_EM_LD
    } ctrl_state_t;

endpackage

FILE: src/haar_2d_block_transform.sv
// One-level 2D Haar transform of a square block of BLOCK_SIZE x BLOCK_SIZE
// signed Q11.4 samples.
//
// Channels: samples arrive on in_valid/in_ready (sample_value) in row-major
// order. Coefficients leave on out_valid/out_ready (coefficient, with
// last_of_block set on the final one), also row-major. The direction
// register (0 forward, 1 inverse) is written over cfg_valid/cfg_ready and is
// sampled when the last sample of a block is taken.
//
// Timing: a sample is taken every cycle while loading. After the last one,
// two passes run between two ping-pong memories, one butterfly at a time:
// a pair of reads (ST_RD_A, ST_RD_B), then a pair of writes (ST_WR_LO,
// ST_WR_HI). Coefficients are then read back from memory 0 one at a time,
// a read (ST_EM_RD) then a load into the output register (ST_EM_LD);
// no block is taken until the last coefficient is loaded. One read and
// one write port per memory are used in turn, never overlapped.
// Reset returns the block to loading at the start of a block with the
// forward direction; memory contents are not cleared. When the receiver
// stalls, the output register holds its transaction and the read-back
// pauses; no coefficient is dropped.
module haar_2d_block_transform #(
    parameter int BLOCK_SIZE = hbt_pkg::BLOCK_SIZE_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic                              cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [hbt_pkg::DATA_W-1:0] sample_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [hbt_pkg::DATA_W-1:0] coefficient,
    output logic                              last_of_block
);

    localparam int CELLS = BLOCK_SIZE * BLOCK_SIZE;
    localparam int CW    = $clog2(CELLS);
    localparam int LW    = $clog2(BLOCK_SIZE);
    localparam int HALF  = BLOCK_SIZE / 2;
    localparam int ODD   = BLOCK_SIZE % 2;
    localparam int KLAST = (BLOCK_SIZE - 1) / 2;
    localparam int DW    = hbt_pkg::DATA_W;

    hbt_pkg::ctrl_state_t state_reg, state_next;

    logic          direction_reg, direction_next;
    logic          run_dir_reg, run_dir_next;
    logic          pass_reg, pass_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [LW-1:0] line_reg, line_next;
    logic [LW-1:0] k_reg, k_next;
    logic          out_valid_reg, out_valid_next;

    // Payload registers.
    logic signed [DW-1:0] a_reg, a_next;
    logic signed [DW-1:0] b_reg, b_next;
    logic signed [DW-1:0] coef_reg, coef_next;
    logic                 last_reg, last_next;

    // Memory ports.
    logic          m0_wr_en, m0_rd_en, m1_wr_en, m1_rd_en;
    logic [CW-1:0] m0_wr_addr, m0_rd_addr, m1_wr_addr, m1_rd_addr;
    logic [DW-1:0] m0_wr_data, m1_wr_data, m0_rd_data, m1_rd_data;

    logic signed [DW-1:0] src_data;
    logic signed [DW-1:0] bf_b;
    logic signed [DW-1:0] bf_lo, bf_hi;

    logic          is_row;
    logic          tail;
    logic [LW:0]   two_k;
    logic [LW:0]   two_k1;
    logic [LW-1:0] pos_even, pos_odd, pos_half, pos_end;
    logic [LW-1:0] src_a_pos, src_b_pos, dst_lo_pos, dst_hi_pos;
    logic [LW-1:0] rd_pos, wr_pos;
    logic [CW-1:0] rd_addr, wr_addr;
    logic          pass_wr;
    logic signed [DW-1:0] pass_wr_data;
    logic          in_fire, out_free;

    assign cfg_ready     = 1'b1;
    assign in_ready      = (state_reg == hbt_pkg::ST_LOAD);
    assign out_valid     = out_valid_reg;
    assign coefficient   = coef_reg;
    assign last_of_block = last_reg;

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // Forward: rows then columns. Inverse: columns then rows.
    assign is_row = !(pass_reg ^ run_dir_reg);
    assign tail   = (ODD != 0) && (k_reg == LW'(KLAST));

    // Positions within a line for the current pair.
    assign two_k    = {k_reg, 1'b0};
    assign two_k1   = two_k + (LW + 1)'(1);
    assign pos_even = two_k[LW-1:0];
    assign pos_odd  = two_k1[LW-1:0];
    assign pos_half = LW'(HALF) + k_reg;
    assign pos_end  = LW'(BLOCK_SIZE - 1);

    always_comb
    begin
        if (tail)
        begin
            // Unpaired end of an odd line passes through.
            src_a_pos  = pos_end;
            src_b_pos  = pos_end;
            dst_lo_pos = pos_end;
            dst_hi_pos = pos_end;
        end
        else if (run_dir_reg)
        begin
            src_a_pos  = k_reg;
            src_b_pos  = pos_half;
            dst_lo_pos = pos_even;
            dst_hi_pos = pos_odd;
        end
        else
        begin
            src_a_pos  = pos_even;
            src_b_pos  = pos_odd;
            dst_lo_pos = k_reg;
            dst_hi_pos = pos_half;
        end
    end

    assign rd_pos = (state_reg == hbt_pkg::ST_RD_B) ? src_b_pos : src_a_pos;
    assign wr_pos = (state_reg == hbt_pkg::ST_WR_HI) ? dst_hi_pos : dst_lo_pos;

    assign rd_addr = is_row
        ? CW'(CW'(line_reg) * CW'(BLOCK_SIZE)) + CW'(rd_pos)
        : CW'(CW'(rd_pos) * CW'(BLOCK_SIZE)) + CW'(line_reg);
    assign wr_addr = is_row
        ? CW'(CW'(line_reg) * CW'(BLOCK_SIZE)) + CW'(wr_pos)
        : CW'(CW'(wr_pos) * CW'(BLOCK_SIZE)) + CW'(line_reg);

    assign src_data = pass_reg ? m1_rd_data : m0_rd_data;
    assign bf_b     = (state_reg == hbt_pkg::ST_WR_LO) ? src_data : b_reg;

    hbt_butterfly u_butterfly (
        .inverse (run_dir_reg),
        .a       (a_reg),
        .b       (bf_b),
        .lo      (bf_lo),
        .hi      (bf_hi)
    );

    always_comb
    begin
        pass_wr      = 1'b0;
        pass_wr_data = bf_lo;

        state_next     = state_reg;
        direction_next = direction_reg;
        run_dir_next   = run_dir_reg;
        pass_next      = pass_reg;
        cnt_next       = cnt_reg;
        line_next      = line_reg;
        k_next         = k_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        coef_next      = coef_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg;

        m0_rd_en   = 1'b0;
        m1_rd_en   = 1'b0;
        m0_rd_addr = rd_addr;
        m1_rd_addr = rd_addr;

        if (cfg_valid && cfg_ready)
        begin
            direction_next = cfg_data;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            hbt_pkg::ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (cnt_reg == CW'(CELLS - 1))
                    begin
                        cnt_next     = '0;
                        run_dir_next = direction_reg;
                        pass_next    = 1'b0;
                        line_next    = '0;
                        k_next       = '0;
                        state_next   = hbt_pkg::ST_RD_A;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                end
            end

            hbt_pkg::ST_RD_A:
            begin
                m0_rd_en   = !pass_reg;
                m1_rd_en   = pass_reg;
                state_next = hbt_pkg::ST_RD_B;
            end

            hbt_pkg::ST_RD_B:
            begin
                // First operand is back; fetch the second unless at the tail.
                a_next     = src_data;
                m0_rd_en   = !pass_reg && !tail;
                m1_rd_en   = pass_reg && !tail;
                state_next = hbt_pkg::ST_WR_LO;
            end

            hbt_pkg::ST_WR_LO:
            begin
                b_next       = src_data;
                pass_wr      = 1'b1;
                pass_wr_data = tail ? src_data : bf_lo;
                state_next   = tail ? hbt_pkg::ST_EM_RD : hbt_pkg::ST_WR_HI;
            end

            hbt_pkg::ST_WR_HI:
            begin
                pass_wr      = 1'b1;
                pass_wr_data = bf_hi;
                state_next   = hbt_pkg::ST_EM_RD;
            end

            hbt_pkg::ST_EM_RD:
            begin
                m0_rd_en   = 1'b1;
                m0_rd_addr = cnt_reg;
                state_next = hbt_pkg::ST_EM_LD;
            end

            hbt_pkg::ST_EM_LD:
            begin
                // Hold the read data until the output register frees up.
                if (out_free)
                begin
                    coef_next      = m0_rd_data;
                    last_next      = (cnt_reg == CW'(CELLS - 1));
                    out_valid_next = 1'b1;
                    if (cnt_reg == CW'(CELLS - 1))
                    begin
                        cnt_next   = '0;
                        state_next = hbt_pkg::ST_LOAD;
                    end
                    else
                    begin
                        cnt_next   = cnt_reg + CW'(1);
                        state_next = hbt_pkg::ST_EM_RD;
                    end
                end
            end

            default:
            begin
                state_next = hbt_pkg::ST_LOAD;
            end
        endcase

        // Advance to the next pair, line or pass once a butterfly is written.
        if ((state_reg == hbt_pkg::ST_WR_HI) ||
            ((state_reg == hbt_pkg::ST_WR_LO) && tail))
        begin
            state_next = hbt_pkg::ST_RD_A;
            if (k_reg == LW'(KLAST))
            begin
                k_next = '0;
                if (line_reg == LW'(BLOCK_SIZE - 1))
                begin
                    line_next = '0;
                    if (pass_reg)
                    begin
                        pass_next  = 1'b0;
                        cnt_next   = '0;
                        state_next = hbt_pkg::ST_EM_RD;
                    end
                    else
                    begin
                        pass_next = 1'b1;
                    end
                end
                else
                begin
                    line_next = line_reg + LW'(1);
                end
            end
            else
            begin
                k_next = k_reg + LW'(1);
            end
        end
    end

    // Memory 0 takes the load and the second pass; memory 1 the first pass.
    always_comb
    begin
        m0_wr_en   = in_fire || (pass_wr && pass_reg);
        m0_wr_addr = in_fire ? cnt_reg : wr_addr;
        m0_wr_data = in_fire ? sample_value : pass_wr_data;
        m1_wr_en   = pass_wr && !pass_reg;
        m1_wr_addr = wr_addr;
        m1_wr_data = pass_wr_data;
    end

    hbt_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (CW)
    ) u_ram0 (
        .clk     (clk),
        .wr_en   (m0_wr_en),
        .wr_addr (m0_wr_addr),
        .wr_data (m0_wr_data),
        .rd_en   (m0_rd_en),
        .rd_addr (m0_rd_addr),
        .rd_data (m0_rd_data)
    );

    hbt_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (CW)
    ) u_ram1 (
        .clk     (clk),
        .wr_en   (m1_wr_en),
        .wr_addr (m1_wr_addr),
        .wr_data (m1_wr_data),
        .rd_en   (m1_rd_en),
        .rd_addr (m1_rd_addr),
        .rd_data (m1_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hbt_pkg::ST_LOAD;
            direction_reg <= 1'b0;
            run_dir_reg   <= 1'b0;
            pass_reg      <= 1'b0;
            cnt_reg       <= '0;
            line_reg      <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            direction_reg <= direction_next;
            run_dir_reg   <= run_dir_next;
            pass_reg      <= pass_next;
            cnt_reg       <= cnt_next;
            line_reg      <= line_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg    <= a_next;
        b_reg    <= b_next;
        coef_reg <= coef_next;
        last_reg <= last_next;
    end

endmodule

FILE: src/hbt_ram.sv
module hbt_ram #(
    parameter int DEPTH  = hbt_pkg::BLOCK_SIZE_DEF * hbt_pkg::BLOCK_SIZE_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [hbt_pkg::DATA_W-1:0] wr_data,
    input  logic                       rd_en,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [hbt_pkg::DATA_W-1:0] rd_data
);

    logic [hbt_pkg::DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: src/hbt_butterfly.sv
module hbt_butterfly (
    input  logic                              inverse,
    input  logic signed [hbt_pkg::DATA_W-1:0] a,
    input  logic signed [hbt_pkg::DATA_W-1:0] b,
    output logic signed [hbt_pkg::DATA_W-1:0] lo,
    output logic signed [hbt_pkg::DATA_W-1:0] hi
);

    localparam int W = hbt_pkg::DATA_W;

    logic signed [W:0] sum;
    logic signed [W:0] diff;
    logic signed [W-1:0] sum_sat;
    logic signed [W-1:0] diff_sat;

    always_comb
    begin
        sum  = {a[W-1], a} + {b[W-1], b};
        diff = {a[W-1], a} - {b[W-1], b};

        // Clamp when the carry bit disagrees with the sign bit.
        if (sum[W] != sum[W-1])
            sum_sat = sum[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else
            sum_sat = sum[W-1:0];

        if (diff[W] != diff[W-1])
            diff_sat = diff[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else
            diff_sat = diff[W-1:0];

        if (inverse)
        begin
            lo = sum_sat;
            hi = diff_sat;
        end
        else
        begin
            // Halve by arithmetic shift: the result always fits.
            lo = sum[W:1];
            hi = diff[W:1];
        end
    end

endmodule

FILE: test/haar_2d_block_transform_tb.sv
`timescale 1ns / 1ps

module haar_2d_block_transform_tb;

    localparam int DATA_W  = hbt_pkg::DATA_W;
    localparam int BS      = hbt_pkg::BLOCK_SIZE_DEF;
    localparam int HALF    = BS / 2;
    localparam int CELLS   = BS * BS;

    localparam logic signed [DATA_W-1:0] S_MAX = 16'sh7fff;
    localparam logic signed [DATA_W-1:0] S_MIN = 16'sh8000;

    // Share of cycles, out of a hundred, in which a side idles or stalls.
    localparam int GAP_PCT       = 45;
    localparam int GAP_BOTH_PCT  = 7;
    // Length of the long receiver hold-off, in clock cycles.
    localparam int HOLDOFF_LEN   = 1200;
    // Quiet cycles let pass once the last coefficient of a phase is in.
    localparam int SETTLE_CYCLES = 16;
    localparam int MAX_REPORTS   = 10;

    typedef enum int {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    typedef enum int {
        BLK_EDGE_FWD,
        BLK_EDGE_INV,
        BLK_RANDOM
    } block_kind_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] coefficient;
        logic                     last_of_block;
    } coeff_rec_t;

    // Clock, reset and the ports of the block; every input known from time zero.
    logic                     clk;
    logic                     rst_n         = 1'b0;
    logic                     cfg_valid     = 1'b0;
    logic                     cfg_ready;
    logic                     cfg_data      = 1'b0;
    logic                     in_valid      = 1'b0;
    logic                     in_ready;
    logic signed [DATA_W-1:0] sample_value  = '0;
    logic                     out_valid;
    logic                     out_ready     = 1'b0;
    logic signed [DATA_W-1:0] coefficient;
    logic                     last_of_block;

    // Stimulus and checking state.
    logic signed [DATA_W-1:0] sample_pending_q [$];
    coeff_rec_t               coeff_expected_q [$];
    idle_mode_t               idle_mode     = IDLE_NONE;
    bit                       holdoff_req   = 1'b0;
    bit                       rx_holdoff    = 1'b0;
    int                       holdoff_left  = 0;
    int                       error_count   = 0;
    int                       coeff_seen    = 0;

    // Own copy of the block's state: the samples of the block being loaded,
    // how many have come, and the direction last written.
    logic signed [DATA_W-1:0] sample_store [CELLS];
    int                       samples_loaded = 0;
    bit                       direction_copy = 1'b0;
    int                       haar_grid [CELLS];

    haar_2d_block_transform #(
        .BLOCK_SIZE    (BS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_value  (sample_value),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .coefficient   (coefficient),
        .last_of_block (last_of_block)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Clamp a wide sum into the signed 16-bit range.
    function automatic int sat16(input int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // One butterfly pass over a single line of the working grid. Forward
    // puts floored pair averages in the low half and floored halved pair
    // differences in the high half; inverse rebuilds pairs as a+d and a-d,
    // saturating. An unpaired last element would simply pass through.
    function automatic void haar_line_pass(input int base, input int stride,
                                           input bit inverse);
        int line [BS];
        int res  [BS];
        for (int k = 0; k < BS; k++)
        begin
            line[k] = haar_grid[base + k * stride];
            res[k]  = line[k];
        end
        for (int k = 0; k < HALF; k++)
        begin
            if (!inverse)
            begin
                res[k]        = (line[2 * k] + line[2 * k + 1]) >>> 1;
                res[HALF + k] = (line[2 * k] - line[2 * k + 1]) >>> 1;
            end
            else
            begin
                res[2 * k]     = sat16(line[k] + line[HALF + k]);
                res[2 * k + 1] = sat16(line[k] - line[HALF + k]);
            end
        end
        for (int k = 0; k < BS; k++)
            haar_grid[base + k * stride] = res[k];
    endfunction

    // Transform the completed block under the current direction and queue
    // every coefficient in row-major order, the last one marked.
    function automatic void haar_predict_block();
        coeff_rec_t rec;
        for (int i = 0; i < CELLS; i++)
            haar_grid[i] = int'(sample_store[i]);
        if (!direction_copy)
        begin
            for (int r = 0; r < BS; r++)
                haar_line_pass(r * BS, 1, 1'b0);
            for (int c = 0; c < BS; c++)
                haar_line_pass(c, BS, 1'b0);
        end
        else
        begin
            for (int c = 0; c < BS; c++)
                haar_line_pass(c, BS, 1'b1);
            for (int r = 0; r < BS; r++)
                haar_line_pass(r * BS, 1, 1'b1);
        end
        for (int i = 0; i < CELLS; i++)
        begin
            rec.coefficient   = haar_grid[i][DATA_W-1:0];
            rec.last_of_block = (i == CELLS - 1);
            coeff_expected_q.push_back(rec);
        end
    endfunction

    // Store one accepted sample; the one that completes a block fires the
    // transform, after which loading starts over.
    function automatic void absorb_sample(input logic signed [DATA_W-1:0] s);
        sample_store[samples_loaded] = s;
        samples_loaded++;
        if (samples_loaded == CELLS)
        begin
            haar_predict_block();
            samples_loaded = 0;
        end
    endfunction

    // Draw whether a side idles this cycle under the current idling mode.
    function automatic bit draw_gap(input bit for_sender);
        int pct;
        case (idle_mode)
            IDLE_SEND: pct = for_sender ? GAP_PCT : 0;
            IDLE_RECV: pct = for_sender ? 0 : GAP_PCT;
            IDLE_BOTH: pct = GAP_BOTH_PCT;
            default:   pct = 0;
        endcase
        return $urandom_range(0, 99) < pct;
    endfunction

    // Random sample: mostly the full range, with extremes and values near
    // zero mixed in so that saturation and floored halving come up often.
    function automatic logic signed [DATA_W-1:0] random_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return DATA_W'($urandom);
        if (r < 85)
        begin
            case ($urandom_range(0, 3))
                0:       return S_MAX;
                1:       return S_MIN;
                2:       return 16'sd0;
                default: return -16'sd1;
            endcase
        end
        return DATA_W'(int'($urandom_range(0, 64)) - 32);
    endfunction

    // Hand-picked block contents. The forward set covers the extremes, the
    // alternating extremes whose difference is widest, and odd negative
    // pairs where the halving rounds downwards. The inverse set drives a+d
    // and a-d past both ends of the range.
    function automatic logic signed [DATA_W-1:0] edge_sample(input block_kind_t kind,
                                                             input int idx);
        int row;
        int col;
        bit lo_half;
        row     = idx / BS;
        col     = idx % BS;
        lo_half = (col < HALF);
        if (kind == BLK_EDGE_FWD)
        begin
            case (row)
                0:       return S_MAX;
                1:       return S_MIN;
                2:       return col[0] ? S_MIN : S_MAX;
                3:       return col[0] ? S_MAX : S_MIN;
                4:       return col[0] ? 16'sd0 : -16'sd1;
                5:       return col[0] ? 16'sd0 : 16'sd1;
                6:       return DATA_W'(-(col + 1));
                default: return DATA_W'($urandom);
            endcase
        end
        case (row)
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return lo_half ? S_MAX : S_MIN;
            3:       return lo_half ? S_MIN : S_MAX;
            4:       return lo_half ? -16'sd1 : 16'sd1;
            5:       return 16'sd0;
            default: return $urandom_range(0, 1) ? S_MAX : S_MIN;
        endcase
    endfunction

    // Append one whole block of samples to the sender's queue.
    task automatic queue_block(input block_kind_t kind);
        for (int i = 0; i < CELLS; i++)
        begin
            if (kind == BLK_RANDOM)
                sample_pending_q.push_back(random_sample());
            else
                sample_pending_q.push_back(edge_sample(kind, i));
        end
    endtask

    // Hold until the sender has nothing left, every coefficient has come
    // back, and the block has had a few quiet cycles to settle.
    task automatic wait_drained();
        while (sample_pending_q.size() != 0 || in_valid || coeff_expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the direction register; only ever called with the block idle.
    task automatic write_direction(input bit dir);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= dir;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid      <= 1'b0;
        direction_copy  = dir;
    endtask

    // Sender: offer the next pending sample, keeping valid and payload
    // steady until the transaction completes; idle at random between them.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                absorb_sample(sample_value);
            if (!in_valid || in_ready)
            begin
                if (sample_pending_q.size() != 0 && !draw_gap(1'b1))
                begin
                    in_valid     <= 1'b1;
                    sample_value <= sample_pending_q.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off: once requested, keep ready low until the
    // hold-off counter runs out, while the sender carries on offering.
    always @(posedge clk)
    begin
        if (holdoff_req && !rx_holdoff)
        begin
            rx_holdoff   <= 1'b1;
            holdoff_left <= HOLDOFF_LEN;
        end
        else if (rx_holdoff)
        begin
            if (holdoff_left <= 1)
                rx_holdoff <= 1'b0;
            holdoff_left <= holdoff_left - 1;
        end
    end

    // Receiver: compare each coefficient transaction against the oldest
    // expectation, field by field, then draw ready for the next cycle.
    always @(posedge clk)
    begin
        coeff_rec_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (coeff_expected_q.size() == 0)
                begin
                    if (error_count < MAX_REPORTS)
                        $display("unexpected coefficient %0d (last %0b) at output %0d",
                                 coefficient, last_of_block, coeff_seen);
                    error_count++;
                end
                else
                begin
                    want = coeff_expected_q.pop_front();
                    if (coefficient !== want.coefficient
                        || last_of_block !== want.last_of_block)
                    begin
                        if (error_count < MAX_REPORTS)
                            $display("mismatch at %0d: coef exp %0d got %0d, last exp %0b got %0b",
                                     coeff_seen, want.coefficient, coefficient,
                                     want.last_of_block, last_of_block);
                        error_count++;
                    end
                end
                coeff_seen++;
            end
            out_ready <= !rx_holdoff && !draw_gap(1'b0);
        end
    end

    // Phases: each starts from an idle block, writes the direction, then
    // queues its blocks and waits for every coefficient before moving on.
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Back-pressure with no idling: two forward blocks offered flat out
        // while the receiver holds off, so the first fills the block and the
        // second is held at input. Hand-picked extremes go first.
        idle_mode = IDLE_NONE;
        write_direction(1'b0);
        holdoff_req <= 1'b1;
        queue_block(BLK_EDGE_FWD);
        queue_block(BLK_RANDOM);
        @(posedge clk);
        holdoff_req <= 1'b0;

        // Light idling on both sides once the first block is out.
        while (coeff_seen < CELLS)
            @(posedge clk);
        idle_mode = IDLE_BOTH;
        wait_drained();

        // Inverse driven into saturation: a bursty sender while loading,
        // then a stalling receiver while the coefficients come back.
        idle_mode = IDLE_SEND;
        write_direction(1'b1);
        queue_block(BLK_EDGE_INV);
        while (sample_pending_q.size() != 0 || in_valid)
            @(posedge clk);
        idle_mode = IDLE_RECV;
        wait_drained();

        repeat (32) @(posedge clk);
        if (error_count == 0 && coeff_expected_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Guard against a hang: far beyond the slowest correct run.
    initial
    begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
